FILE: rtl/hcbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hcbp_pkg;

    localparam int SYM_W    = 8;
    localparam int CODE_W   = 32;
    localparam int LEN_W    = 6;
    localparam int BYTE_W   = 8;
    localparam int BUF_W    = CODE_W + BYTE_W;   // 7 pending bits + one code, byte aligned
    localparam int NBYTES_W = 3;                 // up to five bytes per item

    localparam int MAX_CODE_LEN_DEF  = 32;
    localparam int ALPHABET_SIZE_DEF = 256;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_ENCODE = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;

    localparam logic [SYM_W-1:0] NEWLINE_SYM = 8'd10;
    localparam logic [SYM_W-1:0] END_SYM     = 8'd0;

    typedef struct packed {
        logic [1:0]        command;
        logic [SYM_W-1:0]  symbol;
        logic [CODE_W-1:0] code_bits;
        logic [LEN_W-1:0]  code_length;
    } t_in;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_of_run;
        logic              unknown_symbol;
    } t_out;

    // looked-up item handed from the table stage to the packer
    typedef struct packed {
        logic              valid;
        logic              finish;
        logic              hit;
        logic [CODE_W-1:0] word;
        logic [LEN_W-1:0]  len;
    } t_lookup;

endpackage

`default_nettype wire

FILE: rtl/huffman_code_bit_packer.sv
`timescale 1ns / 1ps
`default_nettype none
// channel  | valid   | stall   | payload
// input    | i_valid | o_stall | i_data (hcbp_pkg::t_in)
// output   | o_valid | i_stall | o_data (hcbp_pkg::t_out)
//
// An item is looked up in the code memory as it is accepted and reaches the packer in the next
// cycle; an item that yields k bytes holds the output register until its k bytes have left
// (one byte per cycle unless the output stalls), up to four for a code of up to 32 bits and
// five for finish. Loads and newlines skip the packer; items completing no byte emit none.
// Synchronous active-low reset clears the valid marks, the packer and both stages.
// A stalled output holds the byte; the input stalls only while the packer is still emitting.

module huffman_code_bit_packer #(
    parameter int MAX_CODE_LEN  = hcbp_pkg::MAX_CODE_LEN_DEF,
    parameter int ALPHABET_SIZE = hcbp_pkg::ALPHABET_SIZE_DEF
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    output logic           o_stall,
    input  hcbp_pkg::t_in  i_data,
    output logic           o_valid,
    input  wire            i_stall,
    output hcbp_pkg::t_out o_data
);

    hcbp_pkg::t_lookup lookup;
    logic              take;
    logic              accept;

    assign o_stall = lookup.valid && !take;
    assign accept  = i_valid && !o_stall;

    hcbp_code_table #(
        .MAX_CODE_LEN  (MAX_CODE_LEN),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_in     (i_data),
        .i_take   (take),
        .o_lookup (lookup)
    );

    hcbp_packer u_packer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_lookup (lookup),
        .o_take   (take),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_data   (o_data)
    );

endmodule

`default_nettype wire

FILE: rtl/hcbp_code_table.sv
`timescale 1ns / 1ps
`default_nettype none

module hcbp_code_table #(
    parameter int MAX_CODE_LEN  = hcbp_pkg::MAX_CODE_LEN_DEF,
    parameter int ALPHABET_SIZE = hcbp_pkg::ALPHABET_SIZE_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_accept,
    input  hcbp_pkg::t_in    i_in,
    input  wire              i_take,
    output hcbp_pkg::t_lookup o_lookup
);

    localparam int LEN_LIM = (MAX_CODE_LEN < hcbp_pkg::CODE_W) ? MAX_CODE_LEN
                                                               : hcbp_pkg::CODE_W;
    localparam int LW = $clog2(LEN_LIM + 1);
    localparam int AW = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;

    logic [hcbp_pkg::CODE_W-1:0] mem_word [ALPHABET_SIZE];
    logic [LW-1:0]               mem_len  [ALPHABET_SIZE];
    logic                        r_entry_valid [ALPHABET_SIZE];

    logic [hcbp_pkg::CODE_W-1:0] r_word;
    logic [LW-1:0]               r_len;
    logic                        r_hit;
    logic                        r_fin;
    logic                        r_s0_valid;
    logic                        n_s0_valid;

    logic                        wr_en;
    logic                        wr_in_range;
    logic [AW-1:0]               wr_addr;
    logic [AW-1:0]               rd_addr;
    logic                        rd_in_range;
    logic [LW-1:0]               sat_len;
    logic                        keep;

    assign wr_in_range = {1'b0, i_in.symbol} < 9'(ALPHABET_SIZE);
    assign wr_addr     = i_in.symbol[AW-1:0];
    assign wr_en       = i_accept && (i_in.command == hcbp_pkg::CMD_LOAD) && wr_in_range;
    assign sat_len     = (i_in.code_length > 6'(LEN_LIM)) ? LW'(LEN_LIM)
                                                          : i_in.code_length[LW-1:0];

    // finish looks up the end marker
    assign rd_addr     = (i_in.command == hcbp_pkg::CMD_FINISH) ?
                         hcbp_pkg::END_SYM[AW-1:0] : i_in.symbol[AW-1:0];
    assign rd_in_range = (i_in.command == hcbp_pkg::CMD_FINISH) || wr_in_range;

    always_comb begin
        case (i_in.command)
            hcbp_pkg::CMD_ENCODE: keep = (i_in.symbol != hcbp_pkg::NEWLINE_SYM);
            hcbp_pkg::CMD_FINISH: keep = 1'b1;
            default:              keep = 1'b0;
        endcase
        if (i_accept) begin
            n_s0_valid = keep;
        end else if (i_take) begin
            n_s0_valid = 1'b0;
        end else begin
            n_s0_valid = r_s0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_word[wr_addr] <= i_in.code_bits;
            mem_len[wr_addr]  <= sat_len;
        end
        if (i_accept) begin
            r_word <= mem_word[rd_addr];
            r_len  <= mem_len[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ALPHABET_SIZE; k++) begin
                r_entry_valid[k] <= 1'b0;
            end
            r_s0_valid <= 1'b0;
            r_hit      <= 1'b0;
            r_fin      <= 1'b0;
        end else begin
            if (wr_en) begin
                r_entry_valid[wr_addr] <= 1'b1;
            end
            if (i_accept) begin
                r_hit <= rd_in_range && r_entry_valid[rd_addr];
                r_fin <= (i_in.command == hcbp_pkg::CMD_FINISH);
            end
            r_s0_valid <= n_s0_valid;
        end
    end

    assign o_lookup.valid  = r_s0_valid;
    assign o_lookup.finish = r_fin;
    assign o_lookup.hit    = r_hit;
    assign o_lookup.word   = r_word;
    assign o_lookup.len    = 6'(r_len);

endmodule

`default_nettype wire

FILE: rtl/hcbp_packer.sv
`timescale 1ns / 1ps
`default_nettype none

module hcbp_packer (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  hcbp_pkg::t_lookup i_lookup,
    output logic              o_take,
    output logic              o_valid,
    input  wire               i_stall,
    output hcbp_pkg::t_out    o_data
);

    localparam int BW = hcbp_pkg::BUF_W;

    logic [6:0]                    r_pend;
    logic [2:0]                    r_pcnt;
    logic [BW-1:0]                 r_buf;
    logic [hcbp_pkg::NBYTES_W-1:0] r_left;
    logic                          r_err;

    logic                          em_free;
    logic [7:0]                    pend_left;
    logic [hcbp_pkg::CODE_W-1:0]   code_left;
    logic [BW-1:0]                 merged;
    logic [5:0]                    cnt;
    logic [2:0]                    full;
    logic [2:0]                    rem;
    logic [BW-1:0]                 after_full;
    logic [7:0]                    tail;
    logic [6:0]                    n_pend;
    logic [2:0]                    n_pcnt;
    logic [hcbp_pkg::NBYTES_W-1:0] nbytes;
    logic [BW-1:0]                 load_buf;

    // emitter takes a new item once its last byte is leaving
    assign em_free = (r_left == '0) || ((r_left == 3'd1) && !i_stall);
    assign o_take  = i_lookup.valid && em_free;

    always_comb begin
        pend_left  = 8'({1'b0, r_pend} << (4'd8 - {1'b0, r_pcnt}));
        code_left  = i_lookup.word << (6'd32 - i_lookup.len);
        merged     = {pend_left, 32'd0} | ({code_left, 8'd0} >> r_pcnt);
        cnt        = {3'd0, r_pcnt} + i_lookup.len;
        full       = cnt[5:3];
        rem        = cnt[2:0];
        after_full = merged << {full, 3'b000};
        tail       = after_full[BW-1 -: 8] >> (4'd8 - {1'b0, rem});

        if (!i_lookup.hit) begin
            nbytes   = 3'd1;
            load_buf = '0;
            n_pend   = r_pend;
            n_pcnt   = r_pcnt;
        end else if (i_lookup.finish) begin
            nbytes   = full + {2'd0, (rem != 3'd0)};
            load_buf = merged;
            n_pend   = '0;
            n_pcnt   = '0;
        end else begin
            nbytes   = full;
            load_buf = merged;
            n_pend   = tail[6:0];
            n_pcnt   = rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_pcnt <= '0;
            r_left <= '0;
        end else begin
            if (o_take) begin
                r_pend <= n_pend;
                r_pcnt <= n_pcnt;
            end
            if (o_take && (nbytes != '0)) begin
                r_left <= nbytes;
            end else if ((r_left != '0) && !i_stall) begin
                r_left <= r_left - 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && (nbytes != '0)) begin
            r_buf <= load_buf;
            r_err <= !i_lookup.hit;
        end else if ((r_left != '0) && !i_stall) begin
            r_buf <= r_buf << 8;
        end
    end

    assign o_valid               = (r_left != '0);
    assign o_data.out_byte       = r_buf[BW-1 -: 8];
    assign o_data.last_of_run    = (r_left == 3'd1);
    assign o_data.unknown_symbol = r_err;

endmodule

`default_nettype wire

FILE: rtl/hcbp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module hcbp_checker (
    input wire            i_clk,
    input wire            i_rst_n,
    input wire            o_stall,
    input wire            o_valid,
    input wire            i_stall,
    input hcbp_pkg::t_out o_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_data))
        else $error("stalled output beat changed");

    // error beats carry a zero byte and close the run
    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.unknown_symbol |->
            (o_data.out_byte == 8'd0) && o_data.last_of_run)
        else $error("malformed unknown-symbol beat");

    // with the output side empty the packer can always take the next item
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while output idle");

endmodule

bind huffman_code_bit_packer hcbp_checker u_hcbp_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

`default_nettype wire
